@@ rtl/overcurrent_freq_throttle_governor_macros.svh @@
// assertion macros for the frequency cap governor
// used by the top level; needs nothing else
`ifndef OVERCURRENT_FREQ_THROTTLE_GOVERNOR_MACROS_SVH
`define OVERCURRENT_FREQ_THROTTLE_GOVERNOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define OCFTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define OCFTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ocftg_pkg.sv @@
// shared types, constants and helper functions of the frequency cap governor
// no dependencies; every other file but the macro header imports this package

package ocftg_pkg;

  // sizing
  localparam int NUM_LEVELS  = 5;
  localparam int NUM_DOMAINS = 2;
  localparam int LVL_W       = (NUM_LEVELS > 2) ? $clog2(NUM_LEVELS) : 1;
  localparam int CNT_DEPTH   = NUM_LEVELS * NUM_DOMAINS;
  localparam int ADDR_W      = $clog2(CNT_DEPTH);

  // item field widths
  localparam int FUNC_W = 2;
  localparam int DOM_W  = 1;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 3;
  localparam int FREQ_W = 21;

  // apb port
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = 1;

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(NUM_LEVELS - 1);
  localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

  // frequency per level, fastest first
  localparam int FREQ_LEN = 5;
  localparam int FIDX_W   = $clog2(FREQ_LEN);
  localparam logic [FREQ_W-1:0] FREQ_TBL [FREQ_LEN] = '{
    FREQ_W'(1300000), FREQ_W'(1200000), FREQ_W'(1066000),
    FREQ_W'(935000), FREQ_W'(800000)
  };

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WARN     = 2'd0,
    FUNC_THROTTLE = 2'd1,
    FUNC_RESTORE  = 2'd2,
    FUNC_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE = 1'b0,
    REG_THR  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             detector_mode;
    logic [CNT_W-1:0] count_threshold;
  } cfg_t;

  // request to the count memory, one address shared by read and write
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  wdata;
  } mem_req_t;

  // entry of the count table for a level and domain
  function automatic logic [ADDR_W-1:0] cnt_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [DOM_W-1:0] dom);
    cnt_addr = ADDR_W'(lvl) * ADDR_W'(NUM_DOMAINS) + ADDR_W'(dom);
  endfunction

  // levels past the table use the slowest frequency
  function automatic logic [FREQ_W-1:0] level_freq(input logic [LVL_W-1:0] lvl);
    logic [FIDX_W-1:0] idx;
    if (32'(lvl) >= FREQ_LEN) begin
      idx = FIDX_W'(FREQ_LEN - 1);
    end else begin
      idx = FIDX_W'(lvl);
    end
    level_freq = FREQ_TBL[idx];
  endfunction

endpackage

@@ rtl/ocftg_if.sv @@
// valid/ready channels of the governor: event items in, cap items out
// depends on ocftg_pkg

interface ocftg_evt_if
  import ocftg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DOM_W-1:0]  domain;
  logic [CNT_W-1:0]  detector_count;
  logic              irq_still_pending;

  modport source (output valid, func, domain, detector_count, irq_still_pending,
                  input ready);
  modport sink (input valid, func, domain, detector_count, irq_still_pending,
                output ready);
endinterface

interface ocftg_cap_if
  import ocftg_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DOM_W-1:0]  out_domain;
  logic [CAP_W-1:0]  cap_level;
  logic [FREQ_W-1:0] cap_freq_khz;
  logic              changed;

  modport source (output valid, out_domain, cap_level, cap_freq_khz, changed,
                  input ready);
  modport sink (input valid, out_domain, cap_level, cap_freq_khz, changed,
                output ready);
endinterface

@@ rtl/ocftg_cfg_regs.sv @@
// apb register block: detector mode and count threshold
// depends on ocftg_pkg

module ocftg_cfg_regs
  import ocftg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE: cfg_d.detector_mode   = pwdata[0];
        REG_THR:  cfg_d.count_threshold = pwdata[CNT_W-1:0];
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_MODE: prdata = {{(APB_DW-1){1'b0}}, cfg_q.detector_mode};
      REG_THR:  prdata = APB_DW'(cfg_q.count_threshold);
      default:  prdata = '0;
    endcase
  end

endmodule

@@ rtl/ocftg_count_mem.sv @@
// detector count table: single-port synchronous memory with registered read
// per-entry valid bits make unwritten or cleared entries read as zero; uses ocftg_pkg

module ocftg_count_mem
  import ocftg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mem_req_t         req_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem [CNT_DEPTH];
  logic [CNT_W-1:0] rdata_q;
  logic             rvld_q;
  logic             vld_q [CNT_DEPTH];

  // storage and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  // valid bits, cleared by reset and by a clear item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
      for (int i = 0; i < CNT_DEPTH; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      if (req_i.rd_en) begin
        rvld_q <= vld_q[req_i.addr];
      end
      if (req_i.clr) begin
        for (int i = 0; i < CNT_DEPTH; i++) begin
          vld_q[i] <= 1'b0;
        end
      end else if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

@@ rtl/ocftg_ctrl.sv @@
// event sequencer: per-domain level and pending flags, level walk over the
// count memory, count read-modify-write and the output register; uses ocftg_pkg and ocftg_if

module ocftg_ctrl
  import ocftg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  ocftg_evt_if.sink        evt,
  ocftg_cap_if.source      cap,
  input  cfg_t             cfg_i,
  output mem_req_t         mem_req_o,
  input  logic [CNT_W-1:0] mem_rdata_i,
  output logic             busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_WALK = 5'b00100,
    ST_RMW  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // item held while it is worked on
  func_e            func_q;
  logic [DOM_W-1:0] dom_q;
  logic [CNT_W-1:0] cnt_q;
  logic             irq_q;

  // walk and result
  logic [LVL_W-1:0] cand_q, cand_d, cand_nxt;
  logic             slower_q, slower_d;
  logic [LVL_W-1:0] res_q, res_d;
  logic             chg_q, chg_d;

  // per-domain state
  logic [LVL_W-1:0] lvl_q [NUM_DOMAINS];
  logic [LVL_W-1:0] lvl_d [NUM_DOMAINS];
  logic             pend_q [NUM_DOMAINS];
  logic             pend_d [NUM_DOMAINS];

  // output register
  logic              out_valid_q;
  logic [DOM_W-1:0]  out_dom_q;
  logic [CAP_W-1:0]  out_cap_q;
  logic [FREQ_W-1:0] out_freq_q;
  logic              out_chg_q;

  logic             evt_acc;
  logic             out_load;
  logic             dom_ok;
  logic [LVL_W-1:0] old_lvl;
  logic             walk_stop;

  assign evt.ready = (state_q == ST_IDLE);
  assign evt_acc   = evt.valid & evt.ready;
  assign busy_o    = (state_q != ST_IDLE);

  assign dom_ok    = (32'(dom_q) < NUM_DOMAINS);
  assign old_lvl   = dom_ok ? lvl_q[dom_q] : '0;
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || cap.ready);
  assign cand_nxt  = slower_q ? cand_q + LVL_ONE : cand_q - LVL_ONE;
  assign walk_stop = (mem_rdata_i < cfg_i.count_threshold) ||
                     (slower_q ? (cand_q == LVL_LAST) : (cand_q == LVL_ONE));

  // sequencer
  always_comb begin
    state_d   = state_q;
    cand_d    = cand_q;
    slower_d  = slower_q;
    res_d     = res_q;
    chg_d     = chg_q;
    lvl_d     = lvl_q;
    pend_d    = pend_q;
    mem_req_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (evt_acc) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        res_d   = old_lvl;
        chg_d   = 1'b0;
        if (func_q == FUNC_CLEAR) begin
          // everything back to zero, report level 0
          for (int i = 0; i < NUM_DOMAINS; i++) begin
            lvl_d[i]  = '0;
            pend_d[i] = 1'b0;
          end
          mem_req_o.clr = 1'b1;
          res_d         = '0;
          chg_d         = (old_lvl != '0);
        end else if (dom_ok) begin
          case (func_q)
            FUNC_WARN: begin
              if (!pend_q[dom_q]) begin
                pend_d[dom_q] = 1'b1;
                if (cfg_i.detector_mode && (old_lvl != LVL_LAST)) begin
                  mem_req_o.rd_en = 1'b1;
                  mem_req_o.addr  = cnt_addr(old_lvl, dom_q);
                  state_d         = ST_RMW;
                end
              end
            end
            FUNC_THROTTLE: begin
              pend_d[dom_q] = 1'b0;
              if (old_lvl != LVL_LAST) begin
                if (!cfg_i.detector_mode) begin
                  res_d = old_lvl + LVL_ONE;
                  chg_d = 1'b1;
                end else begin
                  cand_d          = old_lvl + LVL_ONE;
                  slower_d        = 1'b1;
                  mem_req_o.rd_en = 1'b1;
                  mem_req_o.addr  = cnt_addr(old_lvl + LVL_ONE, dom_q);
                  state_d         = ST_WALK;
                end
              end
            end
            FUNC_RESTORE: begin
              if (!irq_q) begin
                if (!cfg_i.detector_mode) begin
                  if (old_lvl != '0) begin
                    res_d = old_lvl - LVL_ONE;
                    chg_d = 1'b1;
                  end
                end else if (old_lvl > LVL_ONE) begin
                  // detector walk toward faster stops at level 1
                  cand_d          = old_lvl - LVL_ONE;
                  slower_d        = 1'b0;
                  mem_req_o.rd_en = 1'b1;
                  mem_req_o.addr  = cnt_addr(old_lvl - LVL_ONE, dom_q);
                  state_d         = ST_WALK;
                end
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // one candidate level per cycle, next read issued while comparing
      ST_WALK: begin
        if (walk_stop) begin
          res_d   = cand_q;
          chg_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          cand_d          = cand_nxt;
          mem_req_o.rd_en = 1'b1;
          mem_req_o.addr  = cnt_addr(cand_nxt, dom_q);
        end
      end

      // add the warning's count to the entry read in the previous cycle
      ST_RMW: begin
        mem_req_o.wr_en = 1'b1;
        mem_req_o.addr  = cnt_addr(old_lvl, dom_q);
        mem_req_o.wdata = mem_rdata_i + cnt_q;
        state_d         = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
          if (dom_ok && (func_q != FUNC_CLEAR)) begin
            lvl_d[dom_q] = res_q;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_DOMAINS; i++) begin
        lvl_q[i]  <= '0;
        pend_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load | (out_valid_q & ~cap.ready);
      lvl_q       <= lvl_d;
      pend_q      <= pend_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (evt_acc) begin
      func_q <= func_e'(evt.func);
      dom_q  <= evt.domain;
      cnt_q  <= evt.detector_count;
      irq_q  <= evt.irq_still_pending;
    end
    cand_q   <= cand_d;
    slower_q <= slower_d;
    res_q    <= res_d;
    chg_q    <= chg_d;
    if (out_load) begin
      out_dom_q  <= dom_q;
      out_cap_q  <= CAP_W'(res_q);
      out_freq_q <= level_freq(res_q);
      out_chg_q  <= chg_q;
    end
  end

  assign cap.valid        = out_valid_q;
  assign cap.out_domain   = out_dom_q;
  assign cap.cap_level    = out_cap_q;
  assign cap.cap_freq_khz = out_freq_q;
  assign cap.changed      = out_chg_q;

endmodule

@@ rtl/overcurrent_freq_throttle_governor.sv @@
// steps: an exec state, then a read-modify-write state for a warning that adds a count, or
// a walk with one count memory read per level in detector mode, then a done state that
// loads the output register once it is free; the single-port count memory paces the walk
// throughput: one item at a time, next item taken the cycle after the result is loaded
// reset: async, clears levels, pending flags, count valid bits, state and config at once
// top level of the frequency cap governor; uses ocftg_pkg, ocftg_if and the macro header

`include "overcurrent_freq_throttle_governor_macros.svh"

module overcurrent_freq_throttle_governor
  import ocftg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  ocftg_evt_if.sink          evt_i,
  ocftg_cap_if.source        cap_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  cfg_t             cfg;
  mem_req_t         mem_req;
  logic [CNT_W-1:0] mem_rdata;
  logic             busy;

  // configuration registers
  ocftg_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // detector count table
  ocftg_count_mem u_count_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // event sequencer
  ocftg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt         (evt_i),
    .cap         (cap_o),
    .cfg_i       (cfg),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .busy_o      (busy)
  );

  // checks
  `OCFTG_ASSERT_IMP(a_mem_single_op, clk_i, rst_ni, mem_req.rd_en,
                    !mem_req.wr_en && !mem_req.clr,
                    "count memory read overlaps a write or clear")
  `OCFTG_ASSERT_NXT(a_thr_write, clk_i, rst_ni,
                    psel && penable && pwrite && (reg_idx_e'(paddr[PADDR_W-1:2]) == REG_THR),
                    cfg.count_threshold == $past(pwdata), "threshold write lost")
  `OCFTG_ASSERT_IMP(a_out_from_busy, clk_i, rst_ni, $rose(cap_o.valid), $past(busy),
                    "result item without an item in work")

endmodule

@@ tb/sv/tb_overcurrent_freq_throttle_governor.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the frequency cap governor: events in, cap items out
// depends on ocftg_pkg, ocftg_if and the governor top level; predicts every cap item

module tb_overcurrent_freq_throttle_governor;
  import ocftg_pkg::*;

  typedef struct packed {
    logic [DOM_W-1:0]  out_domain;
    logic [CAP_W-1:0]  cap_level;
    logic [FREQ_W-1:0] cap_freq_khz;
    logic              changed;
  } cap_item_t;

  localparam logic [FREQ_W-1:0] CAP_KHZ [5] = '{
    FREQ_W'(1300000), FREQ_W'(1200000), FREQ_W'(1066000),
    FREQ_W'(935000), FREQ_W'(800000)
  };
  localparam int DRAIN_LIMIT = 5000;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  ocftg_evt_if evt ();
  ocftg_cap_if cap ();

  overcurrent_freq_throttle_governor dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .cap_o   (cap),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // governor state as predicted
  bit               det_mode;
  logic [CNT_W-1:0] count_thr;
  int               lvl_q [NUM_DOMAINS];
  logic [CNT_W-1:0] cnt_q [CNT_DEPTH];
  bit               pend_q [NUM_DOMAINS];

  cap_item_t cap_expect_q [$];
  int        n_err;
  bit        evt_gaps_on;
  bit        cap_stalls_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_overcurrent_freq_throttle_governor: errors");
    $finish;
  end

  function automatic int count_slot(input int lv, input logic [DOM_W-1:0] dom);
    count_slot = lv * NUM_DOMAINS + int'(dom);
  endfunction

  // work out the cap item an accepted event causes and queue it
  function automatic void predict_cap(input func_e f, input logic [DOM_W-1:0] dom,
                                      input logic [CNT_W-1:0] cnt, input logic irq);
    cap_item_t res;
    int        was;
    int        lv;
    bit        stop;
    was  = lvl_q[dom];
    lv   = was;
    stop = 1'b0;
    case (f)
      FUNC_CLEAR: begin
        foreach (lvl_q[i]) lvl_q[i] = 0;
        foreach (pend_q[i]) pend_q[i] = 1'b0;
        foreach (cnt_q[i]) cnt_q[i] = '0;
        lv = 0;
      end
      FUNC_WARN: begin
        // a pending warning masks further ones; no count at the slowest level
        if (!pend_q[dom]) begin
          pend_q[dom] = 1'b1;
          if (det_mode && lv != NUM_LEVELS - 1) begin
            cnt_q[count_slot(lv, dom)] += cnt;
          end
        end
      end
      FUNC_THROTTLE: begin
        if (!det_mode) begin
          if (lv < NUM_LEVELS - 1) lv++;
        end else begin
          while (lv < NUM_LEVELS - 1 && !stop) begin
            lv++;
            stop = cnt_q[count_slot(lv, dom)] < count_thr;
          end
        end
        pend_q[dom] = 1'b0;
      end
      FUNC_RESTORE: begin
        // detector walk never goes below level 1
        if (!irq) begin
          if (!det_mode) begin
            if (lv > 0) lv--;
          end else begin
            while (lv > 1 && !stop) begin
              lv--;
              stop = cnt_q[count_slot(lv, dom)] < count_thr;
            end
          end
        end
      end
      default: ;
    endcase
    if (f != FUNC_CLEAR) lvl_q[dom] = lv;
    res.out_domain   = dom;
    res.cap_level    = CAP_W'(lv);
    res.cap_freq_khz = CAP_KHZ[(lv > 4) ? 4 : lv];
    res.changed      = (lv != was);
    cap_expect_q.push_back(res);
  endfunction

  // compare each cap item with the oldest prediction
  always @(posedge clk_i) begin : check_caps
    cap_item_t exp_c;
    if (rst_ni && cap.valid && cap.ready) begin
      if (cap_expect_q.size() == 0) begin
        $error("cap item with nothing expected: domain %0d level %0d",
               cap.out_domain, cap.cap_level);
        n_err++;
      end else begin
        exp_c = cap_expect_q.pop_front();
        if (cap.out_domain !== exp_c.out_domain) begin
          $error("out_domain: expected %0d, got %0d", exp_c.out_domain, cap.out_domain);
          n_err++;
        end
        if (cap.cap_level !== exp_c.cap_level) begin
          $error("cap_level: expected %0d, got %0d", exp_c.cap_level, cap.cap_level);
          n_err++;
        end
        if (cap.cap_freq_khz !== exp_c.cap_freq_khz) begin
          $error("cap_freq_khz: expected %0d, got %0d", exp_c.cap_freq_khz,
                 cap.cap_freq_khz);
          n_err++;
        end
        if (cap.changed !== exp_c.changed) begin
          $error("changed: expected %0d, got %0d", exp_c.changed, cap.changed);
          n_err++;
        end
      end
    end
  end

  // cap sink with random stall bursts
  initial begin
    cap.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (cap_stalls_on && $urandom_range(0, 7) == 0) begin
        cap.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      cap.ready <= 1'b1;
    end
  end

  // one event item; valid stays high afterwards until the next item or a drain
  task automatic send_event(input func_e f, input logic [DOM_W-1:0] dom,
                            input logic [CNT_W-1:0] cnt, input logic irq);
    if (evt_gaps_on && $urandom_range(0, 3) == 0) begin
      evt.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    evt.valid             <= 1'b1;
    evt.func              <= f;
    evt.domain            <= dom;
    evt.detector_count    <= cnt;
    evt.irq_still_pending <= irq;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    predict_cap(f, dom, cnt, irq);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODE: det_mode  = val[0];
      REG_THR:  count_thr = val[CNT_W-1:0];
      default:  ;
    endcase
  endtask

  task automatic set_config(input bit mode, input logic [CNT_W-1:0] thr);
    write_reg(REG_MODE, APB_DW'(mode));
    write_reg(REG_THR, APB_DW'(thr));
  endtask

  // stop sending and wait until every cap item is in
  task automatic wait_drain();
    int guard;
    guard = 0;
    evt.valid <= 1'b0;
    while (cap_expect_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (NUM_LEVELS + 4) @(posedge clk_i);
  endtask

  // counts: mostly near the threshold, some extremes and full-range values
  function automatic logic [CNT_W-1:0] pick_count(input logic [CNT_W-1:0] span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) pick_count = '1;
    else if (sel == 1) pick_count = '0;
    else if (sel <= 3) pick_count = $urandom();
    else pick_count = $urandom_range(0, span);
  endfunction

  // random events; clear kept rare so levels get deep
  task automatic send_random_events(input int n, input logic [CNT_W-1:0] span,
                                    input bit idle_ok);
    int    pick;
    func_e f;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        evt_gaps_on   = idle_ok && ($urandom_range(0, 2) != 0);
        cap_stalls_on = idle_ok && ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) f = FUNC_CLEAR;
      else if (pick < 38) f = FUNC_WARN;
      else if (pick < 68) f = FUNC_THROTTLE;
      else f = FUNC_RESTORE;
      send_event(f, DOM_W'($urandom_range(0, 1)), pick_count(span),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // plain one-level steps, saturation, pending mask, irq hold, clear
  task automatic test_plain_steps();
    set_config(1'b0, '1);
    send_event(FUNC_WARN, 1'b0, '1, 1'b1);
    send_event(FUNC_WARN, 1'b0, '0, 1'b0);
    for (int i = 0; i < 5; i++) send_event(FUNC_THROTTLE, 1'b1, '0, 1'b0);
    send_event(FUNC_RESTORE, 1'b1, '1, 1'b1);
    send_event(FUNC_RESTORE, 1'b1, '0, 1'b0);
    send_event(FUNC_RESTORE, 1'b0, '0, 1'b0);
    send_event(FUNC_CLEAR, 1'b1, '1, 1'b1);
  endtask

  // detector walks skipping busy levels, floor at level 1, warning at slowest
  task automatic test_detector_walk();
    wait_drain();
    set_config(1'b1, 32'd100);
    send_event(FUNC_WARN, 1'b0, '1, 1'b0);
    send_event(FUNC_THROTTLE, 1'b0, '0, 1'b0);
    send_event(FUNC_WARN, 1'b0, 32'd200, 1'b0);
    send_event(FUNC_THROTTLE, 1'b0, '0, 1'b0);
    send_event(FUNC_WARN, 1'b0, 32'd150, 1'b0);
    send_event(FUNC_THROTTLE, 1'b0, '0, 1'b0);
    send_event(FUNC_RESTORE, 1'b0, '0, 1'b0);
    send_event(FUNC_THROTTLE, 1'b0, '0, 1'b0);
    for (int i = 0; i < 4; i++) send_event(FUNC_THROTTLE, 1'b1, '0, 1'b0);
    send_event(FUNC_WARN, 1'b1, '1, 1'b0);
    send_event(FUNC_CLEAR, 1'b0, '0, 1'b0);
  endtask

  task automatic test_random_plain();
    wait_drain();
    set_config(1'b0, $urandom());
    send_random_events(300, '1, 1'b1);
  endtask

  task automatic test_random_detector();
    logic [CNT_W-1:0] thr;
    wait_drain();
    thr = $urandom_range(20, 2000);
    set_config(1'b1, thr);
    send_random_events(500, thr, 1'b1);
  endtask

  // threshold zero walks every level; all-ones accepts all but saturated counts
  task automatic test_threshold_extremes();
    wait_drain();
    set_config(1'b1, '0);
    send_random_events(150, 32'd1000, 1'b1);
    wait_drain();
    set_config(1'b1, '1);
    send_random_events(150, '1, 1'b1);
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_unthrottled_tail();
    logic [CNT_W-1:0] thr;
    wait_drain();
    evt_gaps_on   = 1'b0;
    cap_stalls_on = 1'b0;
    thr = $urandom_range(1, 500);
    set_config(1'b1, thr);
    send_random_events(300, thr, 1'b0);
  endtask

  initial begin
    n_err         = 0;
    evt_gaps_on   = 1'b1;
    cap_stalls_on = 1'b1;
    det_mode      = 1'b0;
    count_thr     = '0;
    foreach (lvl_q[i]) lvl_q[i] = 0;
    foreach (pend_q[i]) pend_q[i] = 1'b0;
    foreach (cnt_q[i]) cnt_q[i] = '0;
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    evt.valid             <= 1'b0;
    evt.func              <= FUNC_WARN;
    evt.domain            <= '0;
    evt.detector_count    <= '0;
    evt.irq_still_pending <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_steps();
    test_detector_walk();
    test_random_plain();
    test_random_detector();
    test_threshold_extremes();
    test_unthrottled_tail();

    wait_drain();
    if (cap_expect_q.size() != 0) begin
      $error("%0d cap items never arrived", cap_expect_q.size());
      n_err++;
    end
    if (n_err == 0) begin
      $display("tb_overcurrent_freq_throttle_governor: clean");
    end else begin
      $display("tb_overcurrent_freq_throttle_governor: errors");
    end
    $finish;
  end

endmodule
